[rtl/cpmf_pkg.sv]
// ----------------------------------------------------------------------------
// cpmf_pkg
// Shared constants and command/status types of the combined PRNG field
// element generator.
// ----------------------------------------------------------------------------
package cpmf_pkg;

	localparam logic [63:0] SHIFT_TAP  = 64'h0000_0003_b4f0_bf89;
	localparam logic [31:0] MOD5       = 32'd100000007;
	localparam logic [31:0] MOD2       = 32'd100000037;
	localparam logic [30:0] RESET_SEED = 31'd31;

	// seed pre-reduction subtracts modulus << k for k = RED_TOP down to 0
	localparam logic [2:0] RED_TOP = 3'd4;

	localparam int DIV_BITS = 64;

	// register select, taken from paddr[3]
	localparam logic REG_FIELD_ORDER = 1'b0;
	localparam logic REG_SEED        = 1'b1;

	typedef struct packed {
		logic       load;
		logic       seed_from_reg;
		logic       reduce;
		logic [2:0] red_idx;
		logic       advance;
	} gen_cmd_t;

	typedef struct packed {
		logic start;
		logic load_out;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
	} div_sts_t;

endpackage

[rtl/combined_prng_mod_field_top.sv]
// ----------------------------------------------------------------------------
// combined_prng_mod_field_top
// Random field-element generator with APB configuration and stream ports.
// ----------------------------------------------------------------------------
// After reset the block loads seed 31, pre-reduces it and warms up the
// generators before it takes its first item.
// An item without reseed advances the generators once and reduces the sum by
// a restoring divider that yields one remainder bit a cycle. An item with
// reseed first passes through seed load, pre-reduction and warm-up. A
// finished item waits in the output register, and the next item is taken
// meanwhile. Write registers only while the block is idle: field_order at
// 0x0, seed_value at 0x8.
// ----------------------------------------------------------------------------
module combined_prng_mod_field_top #(
	parameter int WARMUP_STEPS = 213
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	// input items
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [0] reseed, [7:1] zero
	// result items
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata    // [63:0] element, [127:64] raw_value
);
	import cpmf_pkg::*;

	logic [63:0] field_order_q;
	logic [30:0] seed_value_q;
	logic        wr_en;
	logic [63:0] raw_sum;
	logic [63:0] element;
	logic [63:0] raw_value;
	gen_cmd_t    gen_cmd;
	div_cmd_t    div_cmd;
	div_sts_t    div_sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_order_q <= 64'd2;
			seed_value_q  <= RESET_SEED;
		end else if (wr_en) begin
			if (paddr[3] == REG_FIELD_ORDER) begin
				field_order_q <= pwdata;
			end else begin
				seed_value_q <= pwdata[30:0];
			end
		end
	end

	assign prdata = (paddr[3] == REG_SEED) ? {33'd0, seed_value_q} : field_order_q;

	cpmf_ctrl #(
		.WARMUP_STEPS(WARMUP_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_reseed(s_axis_tdata[0]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.gen_cmd  (gen_cmd),
		.div_cmd  (div_cmd),
		.div_sts  (div_sts)
	);

	cpmf_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (gen_cmd),
		.seed_value(seed_value_q),
		.raw_sum   (raw_sum)
	);

	cpmf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.sts      (div_sts),
		.dividend (raw_sum),
		.divisor  (field_order_q),
		.element  (element),
		.raw_value(raw_value)
	);

	assign m_axis_tdata = {raw_value, element};

endmodule

[rtl/cpmf_gen.sv]
// ----------------------------------------------------------------------------
// cpmf_gen
// Generator datapath: 64-bit Galois shift register, x*5 mod 100000007 and
// x*2 mod 100000037, with seed load, seed pre-reduction and the wrapped sum.
// ----------------------------------------------------------------------------
module cpmf_gen (
	input  logic              clk,
	input  logic              arst_n,
	input  cpmf_pkg::gen_cmd_t cmd,
	input  logic [30:0]       seed_value,
	output logic [63:0]       raw_sum
);
	import cpmf_pkg::*;

	logic [63:0] shift_q;
	logic [31:0] m5_q;
	logic [31:0] m2_q;

	logic [30:0] seed;
	logic [31:0] mod5_sh;
	logic [31:0] mod2_sh;
	logic [34:0] p5;
	logic [34:0] m5x1, m5x2, m5x3, m5x4;
	logic [32:0] p2;
	logic [32:0] m2x1;
	logic [31:0] m5_next;
	logic [31:0] m2_next;
	logic [63:0] shift_next;

	assign seed    = cmd.seed_from_reg ? seed_value : RESET_SEED;
	assign mod5_sh = MOD5 << cmd.red_idx;
	assign mod2_sh = MOD2 << cmd.red_idx;

	assign p5   = ({3'b0, m5_q} << 2) + {3'b0, m5_q};
	assign m5x1 = {3'b0, MOD5};
	assign m5x2 = {2'b0, MOD5, 1'b0};
	assign m5x3 = m5x2 + m5x1;
	assign m5x4 = {1'b0, MOD5, 2'b0};
	assign p2   = {m2_q, 1'b0};
	assign m2x1 = {1'b0, MOD2};

	always_comb begin
		// quotient of 5x by the modulus is at most four once x is in range
		if (p5 >= m5x4) begin
			m5_next = 32'(p5 - m5x4);
		end else if (p5 >= m5x3) begin
			m5_next = 32'(p5 - m5x3);
		end else if (p5 >= m5x2) begin
			m5_next = 32'(p5 - m5x2);
		end else if (p5 >= m5x1) begin
			m5_next = 32'(p5 - m5x1);
		end else begin
			m5_next = p5[31:0];
		end
		m2_next    = (p2 >= m2x1) ? 32'(p2 - m2x1) : p2[31:0];
		shift_next = {shift_q[62:0], 1'b0} ^ (shift_q[63] ? SHIFT_TAP : 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			m5_q    <= '0;
			m2_q    <= '0;
		end else if (cmd.load) begin
			shift_q <= {33'd0, seed};
			m5_q    <= {1'b0, seed};
			m2_q    <= {1'b0, seed};
		end else if (cmd.reduce) begin
			// only the multiplicative generators need bringing into range
			if (m5_q >= mod5_sh) begin
				m5_q <= m5_q - mod5_sh;
			end
			if (m2_q >= mod2_sh) begin
				m2_q <= m2_q - mod2_sh;
			end
		end else if (cmd.advance) begin
			shift_q <= shift_next;
			m5_q    <= m5_next;
			m2_q    <= m2_next;
		end
	end

	assign raw_sum = shift_q + {32'd0, m5_q} + {32'd0, m2_q};

endmodule

[rtl/cpmf_div.sv]
// ----------------------------------------------------------------------------
// cpmf_div
// Restoring divider, one remainder bit per cycle, plus the result register.
// ----------------------------------------------------------------------------
module cpmf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cpmf_pkg::div_cmd_t  cmd,
	output cpmf_pkg::div_sts_t  sts,
	input  logic [63:0]        dividend,
	input  logic [63:0]        divisor,
	output logic [63:0]        element,
	output logic [63:0]        raw_value
);
	import cpmf_pkg::*;

	localparam int CNT_W = $clog2(DIV_BITS);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [63:0]       rem_q;
	logic [63:0]       dvd_q;
	logic [63:0]       dvs_q;
	logic [63:0]       raw_q;
	logic [63:0]       el_q;
	logic [63:0]       raw_out_q;
	logic [64:0]       trial;
	logic [64:0]       diff;

	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_BITS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
			raw_q <= dividend;
		end else if (busy_q) begin
			// a zero divisor always subtracts nothing, leaving the dividend
			rem_q <= diff[64] ? trial[63:0] : diff[63:0];
			dvd_q <= {dvd_q[62:0], 1'b0};
		end
		if (cmd.load_out) begin
			el_q      <= rem_q;
			raw_out_q <= raw_q;
		end
	end

	assign sts.busy  = busy_q;
	assign element   = el_q;
	assign raw_value = raw_out_q;

endmodule

[rtl/cpmf_ctrl.sv]
// ----------------------------------------------------------------------------
// cpmf_ctrl
// Sequencer: seed load, pre-reduction and warm-up after reset and reseed,
// step, divide and hand-off of the result item.
// ----------------------------------------------------------------------------
module cpmf_ctrl #(
	parameter int WARMUP_STEPS = 213
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_reseed,
	output logic               out_valid,
	input  logic               out_ready,
	output cpmf_pkg::gen_cmd_t  gen_cmd,
	output cpmf_pkg::div_cmd_t  div_cmd,
	input  cpmf_pkg::div_sts_t  div_sts
);
	import cpmf_pkg::*;

	localparam int CW = (WARMUP_STEPS < 1) ? 1 : $clog2(WARMUP_STEPS + 1);

	typedef enum logic [6:0] {
		ST_LOAD   = 7'b0000001,
		ST_REDUCE = 7'b0000010,
		ST_WARM   = 7'b0000100,
		ST_IDLE   = 7'b0001000,
		ST_STEP   = 7'b0010000,
		ST_START  = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	state_t        state_q;
	state_t        state_d;
	logic          item_q;
	logic [2:0]    red_cnt_q;
	logic [CW-1:0] warm_cnt_q;
	logic          out_vld_q;
	logic          warm_done;
	logic          out_free;
	logic          accept;

	assign warm_done = (warm_cnt_q == CW'(WARMUP_STEPS));
	assign out_free  = !out_vld_q || out_ready;
	assign accept    = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		gen_cmd = '0;
		div_cmd = '0;
		gen_cmd.seed_from_reg = item_q;
		gen_cmd.red_idx       = red_cnt_q;
		case (state_q)
			ST_LOAD: begin
				gen_cmd.load = 1'b1;
				state_d      = ST_REDUCE;
			end
			ST_REDUCE: begin
				gen_cmd.reduce = 1'b1;
				if (red_cnt_q == '0) begin
					state_d = ST_WARM;
				end
			end
			ST_WARM: begin
				if (warm_done) begin
					state_d = item_q ? ST_STEP : ST_IDLE;
				end else begin
					gen_cmd.advance = 1'b1;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = in_reseed ? ST_LOAD : ST_STEP;
				end
			end
			ST_STEP: begin
				gen_cmd.advance = 1'b1;
				state_d         = ST_START;
			end
			ST_START: begin
				div_cmd.start = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				// hold until the divider finishes and the result slot frees
				if (!div_sts.busy && out_free) begin
					div_cmd.load_out = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			item_q     <= 1'b0;
			red_cnt_q  <= RED_TOP;
			warm_cnt_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				item_q <= 1'b1;
			end
			if (state_q == ST_LOAD) begin
				red_cnt_q  <= RED_TOP;
				warm_cnt_q <= '0;
			end else if (state_q == ST_REDUCE) begin
				red_cnt_q <= red_cnt_q - 1'b1;
			end else if (state_q == ST_WARM && !warm_done) begin
				warm_cnt_q <= warm_cnt_q + 1'b1;
			end
			if (div_cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_vld_q;

endmodule

[rtl/cpmf_chk.sv]
// ----------------------------------------------------------------------------
// cpmf_chk
// Port-level checks of the field-element generator, bound to the top level.
// ----------------------------------------------------------------------------
module cpmf_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);

	// a result waits until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// one item at a time: the input closes right after an item is taken
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input stayed open after an item was taken");

	// a remainder never exceeds its dividend
	a_elem_le_raw: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63:0] <= m_axis_tdata[127:64])
		else $error("element larger than raw value");

endmodule

bind combined_prng_mod_field_top cpmf_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
